// ===== sv/ndrt_pkg.sv =====
// ndrt_pkg: shared types and constants for the n-density read trimmer
// no dependencies; imported by every module of the block

package ndrt_pkg;

	// position counter width, derived widths, score and gain widths
	localparam int POS_W   = 16;
	localparam int LEN_W   = POS_W + 1;
	localparam int EXT_W   = ((POS_W > 16) ? POS_W : 16) + 2;
	localparam int SCORE_W = 25;
	localparam int GAIN_W  = 7;

	// scoring constants
	localparam logic [7:0]         BASE_N       = 8'h4E;
	localparam logic [GAIN_W-1:0]  GAIN_RESET   = 7'd30;
	localparam logic signed [SCORE_W-1:0] PENALTY_NEG = -25'sd100;

	// one base of a read window
	typedef struct packed {
		logic [7:0]  nucleotide;
		logic        first_item;
		logic        last_item;
		logic [15:0] window_start;
		logic        required_valid;
		logic [15:0] region_start;
		logic [15:0] region_length;
	} item_t;

	// one trimming result
	typedef struct packed {
		logic [15:0] trimmed_start;
		logic [16:0] trimmed_length;
	} result_t;

	// input register contents seen by the datapath
	typedef struct packed {
		logic  valid;
		item_t item;
	} slot_t;

	// result handed to the output register
	typedef struct packed {
		logic    push;
		result_t res;
	} push_t;

endpackage

// ===== sv/ndrt_in_reg.sv =====
// ndrt_in_reg: input register stage of the trimmer
// depends on ndrt_pkg

module ndrt_in_reg import ndrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_data,
	input  logic  take,
	output slot_t slot
);

	logic  valid_s1;
	item_t item_s1;

	// free when empty or when the held item is consumed this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.item  = item_s1;

endmodule

// ===== sv/ndrt_core.sv =====
// ndrt_core: per-base scoring, segment tracking and result formation
// depends on ndrt_pkg; fed by ndrt_in_reg, feeds ndrt_out_reg

module ndrt_core import ndrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [GAIN_W-1:0] cfg_data,
	input  slot_t             slot,
	input  logic              out_free,
	output logic              take,
	output push_t             push
);

	// saturating add within the signed score range
	function automatic logic signed [SCORE_W-1:0] sat_add(
		input logic signed [SCORE_W-1:0] a,
		input logic signed [SCORE_W-1:0] b
	);
		logic signed [SCORE_W:0] s;
		s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
		if (s[SCORE_W] != s[SCORE_W-1]) begin
			sat_add = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
			                     : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			sat_add = s[SCORE_W-1:0];
		end
	endfunction

	logic [GAIN_W-1:0]         gain_q;
	logic [POS_W-1:0]          pos_q;
	logic [POS_W-1:0]          seg_start_q;
	logic signed [SCORE_W-1:0] prefix_q;
	logic signed [SCORE_W-1:0] suffix_q;
	logic                      in_bad_q;
	logic [POS_W-1:0]          bad_start_q;
	logic [LEN_W-1:0]          best_len_q;
	logic [POS_W-1:0]          best_start_q;

	item_t                     it;
	logic [POS_W-1:0]          base_pos;
	logic [POS_W-1:0]          seg0;
	logic signed [SCORE_W-1:0] pre0, pre1, pre2, pre_n;
	logic signed [SCORE_W-1:0] suf0, suf1, suf2, suf_n;
	logic signed [SCORE_W-1:0] gain_s;
	logic                      bad0, bad_n;
	logic [POS_W-1:0]          bss0, bss_n;
	logic [LEN_W-1:0]          bl0, bl_n;
	logic [POS_W-1:0]          bs0, bs_n;
	logic [POS_W-1:0]          seg_n;
	logic [LEN_W-1:0]          seg_len;
	logic                      close;
	logic [EXT_W-1:0]          s_ext, len_ext, req_end, rs_ext;

	assign it     = slot.item;
	assign take   = slot.valid && (!it.last_item || out_free);
	assign gain_s = SCORE_W'(gain_q);

	// scoring and segment bookkeeping for the base in the input register
	always_comb begin
		base_pos = it.first_item ? POS_W'(it.window_start) : pos_q;
		seg0     = it.first_item ? base_pos : seg_start_q;
		pre0     = it.first_item ? '0 : prefix_q;
		suf0     = it.first_item ? '0 : suffix_q;
		bad0     = it.first_item ? 1'b0 : in_bad_q;
		bss0     = it.first_item ? '0 : bad_start_q;
		bl0      = it.first_item ? '0 : best_len_q;
		bs0      = it.first_item ? '0 : best_start_q;

		// penalty on an N base, then gain, each saturating
		pre1 = (it.nucleotide == BASE_N) ? sat_add(pre0, PENALTY_NEG) : pre0;
		suf1 = (it.nucleotide == BASE_N) ? sat_add(suf0, PENALTY_NEG) : suf0;
		pre2 = sat_add(pre1, gain_s);
		suf2 = sat_add(suf1, gain_s);

		// bad-suffix run tracking
		suf_n = suf2;
		bad_n = bad0;
		bss_n = bss0;
		if (!suf2[SCORE_W-1]) begin
			bad_n = 1'b0;
			suf_n = '0;
		end else if (!bad0) begin
			bad_n = 1'b1;
			bss_n = base_pos;
		end

		// segment close on negative prefix or end of window
		close   = pre2[SCORE_W-1] || it.last_item;
		seg_len = LEN_W'(POS_W'(base_pos - seg0)) + LEN_W'(it.last_item);
		if (bad_n) begin
			seg_len = LEN_W'(POS_W'(bss_n - seg0));
		end
		pre_n = pre2;
		seg_n = seg0;
		bl_n  = bl0;
		bs_n  = bs0;
		if (close) begin
			if (seg_len > bl0) begin
				bl_n = seg_len;
				bs_n = seg0;
			end
			seg_n = base_pos + POS_W'(1);
			bad_n = 1'b0;
			suf_n = '0;
			pre_n = '0;
		end

		// widen to cover the required region
		s_ext   = EXT_W'(bs_n);
		len_ext = EXT_W'(bl_n);
		rs_ext  = EXT_W'(it.region_start);
		req_end = rs_ext + EXT_W'(it.region_length);
		if (it.required_valid) begin
			if (rs_ext < s_ext) begin
				s_ext = rs_ext;
			end
			if (s_ext + len_ext < req_end) begin
				len_ext = req_end - s_ext;
			end
		end
	end

	assign push.push               = take && it.last_item;
	assign push.res.trimmed_start  = s_ext[15:0];
	assign push.res.trimmed_length = len_ext[16:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			seg_start_q  <= '0;
			prefix_q     <= '0;
			suffix_q     <= '0;
			in_bad_q     <= 1'b0;
			bad_start_q  <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
		end else if (take) begin
			pos_q        <= base_pos + POS_W'(1);
			seg_start_q  <= seg_n;
			prefix_q     <= pre_n;
			suffix_q     <= suf_n;
			in_bad_q     <= bad_n;
			bad_start_q  <= bss_n;
			best_len_q   <= bl_n;
			best_start_q <= bs_n;
		end
	end

endmodule

// ===== sv/ndrt_out_reg.sv =====
// ndrt_out_reg: result register of the trimmer
// depends on ndrt_pkg; loaded from ndrt_core

module ndrt_out_reg import ndrt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_q;
	result_t res_q;

	// room for a new result when empty or drained this cycle
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= push.push;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push && out_free) begin
			res_q <= push.res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

// ===== sv/n_density_read_trimmer.sv =====
// n_density_read_trimmer: top level of the n-density read trimmer
// depends on ndrt_pkg, ndrt_in_reg, ndrt_core, ndrt_out_reg
//
// channel   handshake              payload    moves
// in        in_valid / in_ready    in_data    one base per transaction
// out       out_valid / out_ready  out_data   one result after each last base
// cfg       cfg_valid / cfg_ready  cfg_data   n_allowance_percent
//
// one base per cycle unless a last base meets a waiting result; the combinational
// scoring path in ndrt_core between input and result register sets that figure
// out_valid rises when the result of a last base from the input register is loaded
// into the result register, delayed only while the previous result is still waiting
// asynchronous active-low reset clears all window state, gain returns to 30
// the input stalls only when a last base meets a result still waiting
// cfg_ready is always high

module n_density_read_trimmer import ndrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [GAIN_W-1:0] cfg_data
);

	slot_t slot;
	push_t push;
	logic  take;
	logic  out_free;

	assign cfg_ready = 1'b1;

	// input register
	ndrt_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.slot     (slot)
	);

	// scoring datapath and window state
	ndrt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.slot      (slot),
		.out_free  (out_free),
		.take      (take),
		.push      (push)
	);

	// result register
	ndrt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sv/ndrt_checker.sv =====
// ndrt_checker: port-level assertions for n_density_read_trimmer
// depends on ndrt_pkg; attached to the top level by the bind below

module ndrt_checker import ndrt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input item_t             in_data,
	input logic              out_valid,
	input logic              out_ready,
	input result_t           out_data,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	// a waiting result holds until its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// the input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	// a base that is not last never blocks the next one
	a_no_stall_mid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last_item |=> in_ready)
		else $error("input stalled after a middle base");

	// a fresh result follows a last base that passed the input register and ndrt_core
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_item, 2))
		else $error("result without a last base");

	// configuration writes are never held off
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind n_density_read_trimmer ndrt_checker u_ndrt_checker (.*);
